### design/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, disabled during reset
`define TBEQ_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// same-cycle implication
`define TBEQ_ASSERT_IMPLY(label, ante, cons, msg) \
    `TBEQ_ASSERT(label, (ante) |-> (cons), msg)

// next-cycle implication
`define TBEQ_ASSERT_NEXT(label, ante, cons, msg) \
    `TBEQ_ASSERT(label, (ante) |=> (cons), msg)

`endif

### design/tbeq_pkg.sv
package tbeq_pkg;

    localparam int SAMPLE_W  = 16;
    localparam int GAIN_W    = 16;
    localparam int GAIN_FRAC = 12;
    localparam int OUT_W     = 16;
    localparam int TAP_W     = 8;
    localparam int BAND_W    = 2;

    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    localparam logic REQ_SAMPLE = 1'b0;
    localparam logic REQ_COEF   = 1'b1;

    localparam logic [BAND_W-1:0] BAND_LOW  = 2'd0;
    localparam logic [BAND_W-1:0] BAND_MID  = 2'd1;
    localparam logic [BAND_W-1:0] BAND_HIGH = 2'd2;

    localparam logic [1:0] REG_GAIN_LOW  = 2'd0;
    localparam logic [1:0] REG_GAIN_BAND = 2'd1;
    localparam logic [1:0] REG_GAIN_HIGH = 2'd2;

    localparam logic signed [GAIN_W-1:0] GAIN_LOW_RST  = 16'sd4096;
    localparam logic signed [GAIN_W-1:0] GAIN_BAND_RST = 16'sd0;
    localparam logic signed [GAIN_W-1:0] GAIN_HIGH_RST = 16'sd0;

    typedef struct packed {
        logic signed [GAIN_W-1:0] gain_low;
        logic signed [GAIN_W-1:0] gain_band;
        logic signed [GAIN_W-1:0] gain_high;
    } tbeq_gains_t;

    typedef struct packed {
        logic              accept_sample;
        logic              accept_coef;
        logic              mac_issue;
        logic              comb_mul;
        logic              comb_add;
        logic [BAND_W-1:0] band_sel;
        logic              sum;
        logic              round;
        logic              out_load;
    } tbeq_cmd_t;

    typedef struct packed {
        logic last_tap;
    } tbeq_stat_t;

endpackage

### design/tbeq_if.sv
interface tbeq_in_if import tbeq_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic                       req_type;
    logic [BAND_W-1:0]          band;
    logic [TAP_W-1:0]           tap;
    logic signed [SAMPLE_W-1:0] value;

    modport source (output valid, req_type, band, tap, value, input ready);
    modport sink (input valid, req_type, band, tap, value, output ready);
endinterface

interface tbeq_out_if import tbeq_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [OUT_W-1:0] filtered;
    logic                    clipped;

    modport source (output valid, filtered, clipped, input ready);
    modport sink (input valid, filtered, clipped, output ready);
endinterface

### design/tbeq_ram.sv
module tbeq_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 161
) (
    input  logic                                 clk,
    input  logic                                 we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                     wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                     rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### design/tbeq_cfg.sv
module tbeq_cfg import tbeq_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output tbeq_gains_t           gains
);

    tbeq_gains_t gains_reg;
    tbeq_gains_t gains_next;
    logic        wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_comb
    begin
        gains_next = gains_reg;
        if (wr_en)
        begin
            unique case (paddr[3:2])
                REG_GAIN_LOW:  gains_next.gain_low  = pwdata[GAIN_W-1:0];
                REG_GAIN_BAND: gains_next.gain_band = pwdata[GAIN_W-1:0];
                REG_GAIN_HIGH: gains_next.gain_high = pwdata[GAIN_W-1:0];
                default:       gains_next = gains_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_GAIN_LOW:  prdata = APB_DATA_W'(gains_reg.gain_low);
            REG_GAIN_BAND: prdata = APB_DATA_W'(gains_reg.gain_band);
            REG_GAIN_HIGH: prdata = APB_DATA_W'(gains_reg.gain_high);
            default:       prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gains_reg.gain_low  <= GAIN_LOW_RST;
            gains_reg.gain_band <= GAIN_BAND_RST;
            gains_reg.gain_high <= GAIN_HIGH_RST;
        end
        else
        begin
            gains_reg <= gains_next;
        end
    end

    assign gains = gains_reg;

endmodule

### design/tbeq_ctrl.sv
`include "assert_macros.svh"

module tbeq_ctrl import tbeq_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       in_req_type,
    output logic       in_ready,
    output logic       out_valid,
    input  logic       out_ready,
    input  tbeq_stat_t stat,
    output tbeq_cmd_t  cmd
);

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_MAC    = 4'd1;
    localparam logic [3:0] ST_DRAIN0 = 4'd2;
    localparam logic [3:0] ST_DRAIN1 = 4'd3;
    localparam logic [3:0] ST_MUL    = 4'd4;
    localparam logic [3:0] ST_ADD    = 4'd5;
    localparam logic [3:0] ST_SUM    = 4'd6;
    localparam logic [3:0] ST_ROUND  = 4'd7;
    localparam logic [3:0] ST_LOAD   = 4'd8;

    logic [3:0]        state_reg;
    logic [3:0]        state_next;
    logic [BAND_W-1:0] band_reg;
    logic [BAND_W-1:0] band_next;
    logic              out_valid_reg;
    logic              out_valid_next;

    always_comb
    begin
        state_next = state_reg;
        band_next  = band_reg;
        in_ready   = 1'b0;
        cmd        = '0;
        cmd.band_sel = band_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (in_req_type == REQ_SAMPLE)
                    begin
                        cmd.accept_sample = 1'b1;
                        state_next        = ST_MAC;
                    end
                    else
                    begin
                        cmd.accept_coef = 1'b1;
                    end
                end
            end
            ST_MAC:
            begin
                cmd.mac_issue = 1'b1;
                if (stat.last_tap)
                begin
                    state_next = ST_DRAIN0;
                end
            end
            ST_DRAIN0:
            begin
                state_next = ST_DRAIN1;
            end
            ST_DRAIN1:
            begin
                band_next  = BAND_LOW;
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                cmd.comb_mul = 1'b1;
                state_next   = ST_ADD;
            end
            ST_ADD:
            begin
                cmd.comb_add = 1'b1;
                if (band_reg == BAND_HIGH)
                begin
                    state_next = ST_SUM;
                end
                else
                begin
                    band_next  = band_reg + 1'b1;
                    state_next = ST_MUL;
                end
            end
            ST_SUM:
            begin
                cmd.sum    = 1'b1;
                state_next = ST_ROUND;
            end
            ST_ROUND:
            begin
                cmd.round  = 1'b1;
                state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            band_reg      <= BAND_LOW;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            band_reg      <= band_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    `TBEQ_ASSERT_NEXT(a_sample_starts_mac,
        in_valid && in_ready && in_req_type == REQ_SAMPLE,
        state_reg == ST_MAC, "accepted sample did not start the tap sweep")

    `TBEQ_ASSERT_IMPLY(a_no_result_overwrite, cmd.out_load,
        !out_valid_reg || out_ready, "pending result overwritten")

    `TBEQ_ASSERT_IMPLY(a_band_in_range, state_reg == ST_MUL || state_reg == ST_ADD,
        band_reg == BAND_LOW || band_reg == BAND_MID || band_reg == BAND_HIGH,
        "combine step on a nonexistent bank")

endmodule

### design/tbeq_dp.sv
module tbeq_dp import tbeq_pkg::*; #(
    parameter int TAPS      = 161,
    parameter int COEF_BITS = 16
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic [BAND_W-1:0]          in_band,
    input  logic [TAP_W-1:0]           in_tap,
    input  logic signed [SAMPLE_W-1:0] in_value,
    input  tbeq_gains_t                gains,
    input  tbeq_cmd_t                  cmd,
    output tbeq_stat_t                 stat,
    output logic signed [OUT_W-1:0]    filtered,
    output logic                       clipped
);

    localparam int AW     = (TAPS > 1) ? $clog2(TAPS) : 1;
    localparam int FILL_W = $clog2(TAPS + 1);
    localparam int FRAC   = COEF_BITS - 1;
    localparam int PROD_W = SAMPLE_W + COEF_BITS;
    localparam int ACC_W  = PROD_W + $clog2(TAPS);
    localparam int HI_W   = ACC_W - FRAC;
    localparam int MHI_W  = HI_W + GAIN_W;
    localparam int MLO_W  = FRAC + 1 + GAIN_W;
    localparam int HS_W   = MHI_W + 2;
    localparam int LS_W   = MLO_W + 2;
    localparam int TOT_W  = HS_W + FRAC + 1;
    localparam int SH     = FRAC + GAIN_FRAC;
    localparam int Q_W    = TOT_W - SH;
    localparam int UP     = (COEF_BITS >= SAMPLE_W) ? (COEF_BITS - SAMPLE_W) : 0;
    localparam int DOWN   = (COEF_BITS < SAMPLE_W) ? (SAMPLE_W - COEF_BITS) : 0;
    localparam int EXT_W  = COEF_BITS + SAMPLE_W;

    localparam logic signed [Q_W-1:0] Y_MAX = Q_W'((2 ** (OUT_W - 1)) - 1);
    localparam logic signed [Q_W-1:0] Y_MIN = -Y_MAX - Q_W'(1);

    // sample history and tap sweep control
    logic [AW-1:0]     wp_reg;
    logic [AW-1:0]     rd_ptr_reg;
    logic [AW-1:0]     tap_reg;
    logic [FILL_W-1:0] fill_reg;
    logic              s1_valid_reg;
    logic              s1_tapok_reg;
    logic              p_valid_reg;

    // arithmetic
    logic signed [PROD_W-1:0] prod_reg [3];
    logic signed [ACC_W-1:0]  acc_reg [3];
    logic signed [MHI_W-1:0]  mhi_reg;
    logic signed [MLO_W-1:0]  mlo_reg;
    logic signed [HS_W-1:0]   hsum_reg;
    logic signed [LS_W-1:0]   lsum_reg;
    logic signed [TOT_W-1:0]  total_reg;
    logic signed [Q_W-1:0]    q_reg;
    logic signed [OUT_W-1:0]  filtered_reg;
    logic                     clipped_reg;

    logic signed [EXT_W-1:0]     vext;
    logic signed [EXT_W-1:0]     vshift;
    logic [COEF_BITS-1:0]        coef_w;
    logic                        tap_wr_ok;
    logic [2:0]                  coef_we;
    logic [SAMPLE_W-1:0]         smp_rd;
    logic [COEF_BITS-1:0]        coef_rd [3];
    logic signed [SAMPLE_W-1:0]  smp;
    logic signed [ACC_W-1:0]     acc_sel;
    logic signed [GAIN_W-1:0]    gain_sel;
    logic signed [HI_W-1:0]      hi;
    logic signed [FRAC:0]        lo;
    logic signed [Q_W-1:0]       q_floor;
    logic                        frac_nz;
    logic [AW-1:0]               wp_next;
    logic [AW-1:0]               rd_ptr_dec;

    // q1.15 input rescaled to the coefficient format
    assign vext      = EXT_W'(in_value);
    assign vshift    = (vext <<< UP) >>> DOWN;
    assign coef_w    = vshift[COEF_BITS-1:0];
    assign tap_wr_ok = int'(in_tap) < TAPS;

    assign coef_we[0] = cmd.accept_coef && tap_wr_ok && in_band == BAND_LOW;
    assign coef_we[1] = cmd.accept_coef && tap_wr_ok && in_band == BAND_MID;
    assign coef_we[2] = cmd.accept_coef && tap_wr_ok && in_band == BAND_HIGH;

    tbeq_ram #(.WIDTH(SAMPLE_W), .DEPTH(TAPS)) u_delay_ram (
        .clk   (clk),
        .we    (cmd.accept_sample),
        .waddr (wp_reg),
        .wdata (in_value),
        .raddr (rd_ptr_reg),
        .rdata (smp_rd)
    );

    for (genvar b = 0; b < 3; b++)
    begin : g_bank
        tbeq_ram #(.WIDTH(COEF_BITS), .DEPTH(TAPS)) u_coef_ram (
            .clk   (clk),
            .we    (coef_we[b]),
            .waddr (AW'(in_tap)),
            .wdata (coef_w),
            .raddr (tap_reg),
            .rdata (coef_rd[b])
        );
    end

    assign wp_next    = (wp_reg == AW'(TAPS - 1)) ? '0 : wp_reg + 1'b1;
    assign rd_ptr_dec = (rd_ptr_reg == '0) ? AW'(TAPS - 1) : rd_ptr_reg - 1'b1;

    assign stat.last_tap = tap_reg == AW'(TAPS - 1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg       <= '0;
            rd_ptr_reg   <= '0;
            tap_reg      <= '0;
            fill_reg     <= '0;
            s1_valid_reg <= 1'b0;
            s1_tapok_reg <= 1'b0;
            p_valid_reg  <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= cmd.mac_issue;
            s1_tapok_reg <= FILL_W'(tap_reg) < fill_reg;
            p_valid_reg  <= s1_valid_reg;
            if (cmd.accept_sample)
            begin
                wp_reg     <= wp_next;
                rd_ptr_reg <= wp_reg;
                tap_reg    <= '0;
                if (fill_reg != FILL_W'(TAPS))
                begin
                    fill_reg <= fill_reg + 1'b1;
                end
            end
            else if (cmd.mac_issue)
            begin
                rd_ptr_reg <= rd_ptr_dec;
                tap_reg    <= stat.last_tap ? '0 : tap_reg + 1'b1;
            end
        end
    end

    // taps past the number of samples seen read as zero
    assign smp = s1_tapok_reg ? $signed(smp_rd) : '0;

    always_comb
    begin
        case (cmd.band_sel)
            BAND_LOW:
            begin
                acc_sel  = acc_reg[0];
                gain_sel = gains.gain_low;
            end
            BAND_MID:
            begin
                acc_sel  = acc_reg[1];
                gain_sel = gains.gain_band;
            end
            default:
            begin
                acc_sel  = acc_reg[2];
                gain_sel = gains.gain_high;
            end
        endcase
    end

    assign hi      = acc_sel[ACC_W-1:FRAC];
    assign lo      = {1'b0, acc_sel[FRAC-1:0]};
    assign q_floor = total_reg[TOT_W-1:SH];
    assign frac_nz = |total_reg[SH-1:0];

    always_ff @(posedge clk)
    begin
        for (int b = 0; b < 3; b++)
        begin
            prod_reg[b] <= PROD_W'(smp) * PROD_W'($signed(coef_rd[b]));
            if (cmd.accept_sample)
            begin
                acc_reg[b] <= '0;
            end
            else if (p_valid_reg)
            begin
                acc_reg[b] <= acc_reg[b] + ACC_W'(prod_reg[b]);
            end
        end

        if (cmd.comb_mul)
        begin
            mhi_reg <= MHI_W'(hi) * MHI_W'(gain_sel);
            mlo_reg <= MLO_W'(lo) * MLO_W'(gain_sel);
        end

        if (cmd.accept_sample)
        begin
            hsum_reg <= '0;
            lsum_reg <= '0;
        end
        else if (cmd.comb_add)
        begin
            hsum_reg <= hsum_reg + HS_W'(mhi_reg);
            lsum_reg <= lsum_reg + LS_W'(mlo_reg);
        end

        if (cmd.sum)
        begin
            total_reg <= (TOT_W'(hsum_reg) <<< FRAC) + TOT_W'(lsum_reg);
        end

        // truncate toward zero
        if (cmd.round)
        begin
            q_reg <= (total_reg[TOT_W-1] && frac_nz) ? q_floor + Q_W'(1) : q_floor;
        end

        if (cmd.out_load)
        begin
            if (q_reg > Y_MAX)
            begin
                filtered_reg <= Y_MAX[OUT_W-1:0];
                clipped_reg  <= 1'b1;
            end
            else if (q_reg < Y_MIN)
            begin
                filtered_reg <= Y_MIN[OUT_W-1:0];
                clipped_reg  <= 1'b1;
            end
            else
            begin
                filtered_reg <= q_reg[OUT_W-1:0];
                clipped_reg  <= 1'b0;
            end
        end
    end

    assign filtered = filtered_reg;
    assign clipped  = clipped_reg;

endmodule

### design/three_band_fir_equalizer_top.sv
// channel   kind           payload
// in_ch     valid/ready    req_type, band, tap, value
// out_ch    valid/ready    filtered, clipped
// apb       psel/penable   gain_low @0x0, gain_band @0x4, gain_high @0x8
//
// a coefficient write gives no result
// a sample is swept one tap per cycle through three parallel macs
// and the delay-line ram port, then shared gain multipliers and rounding steps
// the next item is taken while a finished result waits in the output register
// reset clears the delay line through a fill count, coefficients stay unwritten
module three_band_fir_equalizer_top import tbeq_pkg::*; #(
    parameter int TAPS      = 161,
    parameter int COEF_BITS = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    tbeq_in_if.sink               in_ch,
    tbeq_out_if.source            out_ch,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    tbeq_gains_t gains;
    tbeq_cmd_t   cmd;
    tbeq_stat_t  stat;
    logic        in_ready;
    logic        out_valid;

    tbeq_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .gains   (gains)
    );

    tbeq_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_ch.valid),
        .in_req_type (in_ch.req_type),
        .in_ready    (in_ready),
        .out_valid   (out_valid),
        .out_ready   (out_ch.ready),
        .stat        (stat),
        .cmd         (cmd)
    );

    tbeq_dp #(.TAPS(TAPS), .COEF_BITS(COEF_BITS)) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_band  (in_ch.band),
        .in_tap   (in_ch.tap),
        .in_value (in_ch.value),
        .gains    (gains),
        .cmd      (cmd),
        .stat     (stat),
        .filtered (out_ch.filtered),
        .clipped  (out_ch.clipped)
    );

    assign in_ch.ready  = in_ready;
    assign out_ch.valid = out_valid;

endmodule
